### hw/rtl/idf_pkg.sv
// shared types and constants of the image deglitch filter
`timescale 1ns / 1ps

package idf_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd2;

    localparam int SIZE_REG_W   = 6;
    localparam int THRESH_REG_W = 8;

    localparam logic [SIZE_REG_W-1:0]   ROWS_RESET   = 6'd20;
    localparam logic [SIZE_REG_W-1:0]   COLS_RESET   = 6'd30;
    localparam logic [THRESH_REG_W-1:0] THRESH_RESET = 8'd1;

    // stream field widths
    localparam int PIXEL_FIELD_W = 8;
    localparam int ROW_FIELD_W   = 5;
    localparam int COL_FIELD_W   = 5;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 24;

    // controller to datapath
    typedef struct packed {
        logic take;   // item accepted this cycle
        logic read;   // line store read
        logic calc;   // neighbor compare and sum
        logic div;    // average and select
        logic emit;   // result loaded into output register
        logic flush;  // working on the final row
    } idf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic first_row;   // incoming item belongs to row 0
        logic frame_end;   // current item closes the frame
        logic flush_last;  // current column is the last one
        logic out_free;    // output register can take a result
    } idf_status_t;

endpackage

### hw/rtl/image_deglitch_filter.sv
// top level of the image deglitch filter: configuration registers, controller, datapath
`timescale 1ns / 1ps

// channel   direction  signals                          item
// s_        in         s_tvalid s_tready s_tdata        one raw pixel in raster order
// m_        out        m_tvalid m_tready m_tdata        one filtered pixel with row and column
//                      m_tlast m_tuser
// cfg_      in         cfg_valid cfg_ready cfg_index    one register write
//                      cfg_data
//
// a pixel of row 0 is only accepted; any other pixel steps through accept, line store
// read, neighbor compare and sum, average and output load on the shared filter path
// the last pixel of a frame adds a read to output load pass per final row column, same path
// a stalled output holds the controller in the output load step; input waits meanwhile
// reset clears counters, left neighbor and output valid; line stores are not cleared
// configuration writes are taken in any cycle, ready is always high

module image_deglitch_filter
#(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // [7:0] in_pixel
    input  logic [idf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] out_pixel, [12:8] out_row, [17:13] out_col, [23:18] zero
    output logic [idf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              m_tlast,   // last_in_run
    // [0] frame_done
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [idf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [idf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_COLS+1);
    localparam int RW = $clog2(MAX_ROWS+1);

    logic [idf_pkg::SIZE_REG_W-1:0]   rows_reg;
    logic [idf_pkg::SIZE_REG_W-1:0]   cols_reg;
    logic [idf_pkg::THRESH_REG_W-1:0] thresh_reg;
    logic [RW-1:0]                    erows;
    logic [CW-1:0]                    ecols;

    idf_pkg::idf_cmd_t    cmd;
    idf_pkg::idf_status_t sts;

    assign cfg_ready = 1'b1;

    // register file, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= idf_pkg::ROWS_RESET;
            cols_reg   <= idf_pkg::COLS_RESET;
            thresh_reg <= idf_pkg::THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                idf_pkg::CFG_ROWS:      rows_reg   <= cfg_data[idf_pkg::SIZE_REG_W-1:0];
                idf_pkg::CFG_COLS:      cols_reg   <= cfg_data[idf_pkg::SIZE_REG_W-1:0];
                idf_pkg::CFG_THRESHOLD: thresh_reg <= cfg_data[idf_pkg::THRESH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // frame sizes saturated to two up to the build limits
    always_comb
    begin
        if (rows_reg < 6'd2)
            erows = RW'(2);
        else if (32'(rows_reg) > MAX_ROWS)
            erows = RW'(MAX_ROWS);
        else
            erows = RW'(rows_reg);

        if (cols_reg < 6'd2)
            ecols = CW'(2);
        else if (32'(cols_reg) > MAX_COLS)
            ecols = CW'(MAX_COLS);
        else
            ecols = CW'(cols_reg);
    end

    idf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    idf_datapath
    #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .erows     (erows),
        .ecols     (ecols),
        .threshold (thresh_reg),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // a result is only loaded when the output register has room
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded into a full output register");

    // the final row is never in progress while input is open
    a_no_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.flush)
        else $error("input open during final row flush");

    // a pixel beyond row 0 closes the input until its result is out
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !sts.first_row) |=> !s_tready)
        else $error("input reopened while a pixel is in the filter");

    // the last column of the flush hands back to idle
    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.flush && sts.flush_last) |=> s_tready)
        else $error("flush did not return to idle");

endmodule

### hw/rtl/idf_ctrl.sv
// controller state machine of the image deglitch filter
`timescale 1ns / 1ps

module idf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  idf_pkg::idf_status_t sts,
    output idf_pkg::idf_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_CALC = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        s_tready   = (state_reg == ST_IDLE);
        cmd.take   = s_tready && s_tvalid;
        cmd.read   = (state_reg == ST_READ);
        cmd.calc   = (state_reg == ST_CALC);
        cmd.div    = (state_reg == ST_DIV);
        cmd.emit   = (state_reg == ST_EMIT) && sts.out_free;
        cmd.flush  = flush_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // row 0 only fills the line store
                    state_next = sts.first_row ? ST_IDLE : ST_READ;
                end
            end
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_DIV;
            ST_DIV:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (flush_reg)
                    begin
                        if (sts.flush_last)
                        begin
                            flush_next = 1'b0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else if (sts.frame_end)
                    begin
                        flush_next = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

endmodule

### hw/rtl/idf_datapath.sv
// datapath of the image deglitch filter: counters, line stores, filter, output register
`timescale 1ns / 1ps

module idf_datapath
#(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  idf_pkg::idf_cmd_t                       cmd,
    output idf_pkg::idf_status_t                    sts,
    input  logic [$clog2(MAX_ROWS+1)-1:0]           erows,
    input  logic [$clog2(MAX_COLS+1)-1:0]           ecols,
    input  logic [idf_pkg::THRESH_REG_W-1:0]        threshold,
    input  logic [idf_pkg::S_TDATA_W-1:0]           s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [idf_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                    m_tlast,
    output logic [0:0]                              m_tuser
);

    localparam int AW  = $clog2(MAX_COLS);
    localparam int CW  = $clog2(MAX_COLS+1);
    localparam int RW  = $clog2(MAX_ROWS+1);
    localparam int PW  = PIXEL_BITS;
    localparam int IN_W = (PW > idf_pkg::PIXEL_FIELD_W) ? PW : idf_pkg::PIXEL_FIELD_W;
    localparam int TW  = (PW > idf_pkg::THRESH_REG_W) ? PW : idf_pkg::THRESH_REG_W;
    localparam int ROWX = (RW > idf_pkg::ROW_FIELD_W) ? RW : idf_pkg::ROW_FIELD_W;
    localparam int COLX = (AW > idf_pkg::COL_FIELD_W) ? AW : idf_pkg::COL_FIELD_W;
    localparam int SUM_BITS   = PW + 2;
    localparam int DIV3_SHIFT = SUM_BITS + 2;
    localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;
    localparam int PAD_W = idf_pkg::M_TDATA_W - idf_pkg::PIXEL_FIELD_W
                         - idf_pkg::ROW_FIELD_W - idf_pkg::COL_FIELD_W;

    // frame position counters
    logic [CW-1:0] col_count_reg;
    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] col_wrap;
    logic [RW-1:0] row_wrap;
    logic          item_frame_end;

    // current item
    logic [PW-1:0] px_in;
    logic [IN_W-1:0] px_wide;
    logic [PW-1:0] px_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] col_reg;
    logic          frame_end_reg;
    logic          flush_last;

    // line stores
    logic [PW-1:0] raw_mem  [MAX_COLS];
    logic [PW-1:0] filt_mem [MAX_COLS];
    logic          raw_we;
    logic [AW-1:0] raw_waddr;
    logic [PW-1:0] raw_wdata;
    logic [AW-1:0] right_addr;
    logic [PW-1:0] center_reg, right_reg, up_reg;

    // filter
    logic [PW-1:0]       left_reg;
    logic [PW-1:0]       nb      [4];
    logic                nb_ok   [4];
    logic [PW-1:0]       diff    [4];
    logic                any_close;
    logic [SUM_BITS-1:0] sum;
    logic [2:0]          count;
    logic                keep_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [2:0]          count_reg;
    logic [PROD_BITS-1:0] prod;
    logic [SUM_BITS-1:0] quot;
    logic [PW-1:0]       v_reg;

    // output register
    logic                               out_valid_reg;
    logic [idf_pkg::PIXEL_FIELD_W-1:0]  out_pix_reg;
    logic [idf_pkg::ROW_FIELD_W-1:0]    out_row_reg;
    logic [idf_pkg::COL_FIELD_W-1:0]    out_col_reg;
    logic                               out_last_reg;
    logic                               out_done_reg;
    logic [IN_W-1:0]                    v_wide;
    logic [RW-1:0]                      row_emit;
    logic [ROWX-1:0]                    row_wide;
    logic [COLX-1:0]                    col_wide;

    assign px_wide = IN_W'(s_tdata);
    assign px_in   = px_wide[PW-1:0];

    // position of the incoming item, with wrap for sizes changed mid-frame
    always_comb
    begin
        col_wrap = col_count_reg;
        row_wrap = row_count_reg;
        if (col_count_reg >= ecols)
        begin
            col_wrap = '0;
            row_wrap = row_count_reg + RW'(1);
        end
        if (row_wrap >= erows)
        begin
            row_wrap = '0;
        end
        item_frame_end = (row_wrap == erows - RW'(1)) && (col_wrap == ecols - CW'(1));
    end

    assign flush_last = (CW'(col_reg) + CW'(1)) == ecols;

    assign sts.first_row  = (row_wrap == '0);
    assign sts.frame_end  = frame_end_reg;
    assign sts.flush_last = flush_last;
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            left_reg      <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                col_count_reg <= item_frame_end ? '0 : col_wrap + CW'(1);
                row_count_reg <= item_frame_end ? '0 : row_wrap;
            end
            if (cmd.emit)
            begin
                left_reg <= v_reg;
            end
        end
    end

    // item registers; the column steps through the last row during the flush
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            px_reg        <= px_in;
            row_reg       <= row_wrap;
            col_reg       <= col_wrap[AW-1:0];
            frame_end_reg <= item_frame_end;
        end
        else if (cmd.emit)
        begin
            if (cmd.flush)
            begin
                col_reg <= col_reg + AW'(1);
            end
            else if (frame_end_reg)
            begin
                col_reg <= '0;
            end
        end
    end

    assign raw_we    = (cmd.take && sts.first_row) || (cmd.emit && !cmd.flush);
    assign raw_waddr = cmd.take ? col_wrap[AW-1:0] : col_reg;
    assign raw_wdata = cmd.take ? px_in : px_reg;
    assign right_addr = (32'(col_reg) == MAX_COLS - 1) ? col_reg : col_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (raw_we)
        begin
            raw_mem[raw_waddr] <= raw_wdata;
        end
        if (cmd.emit)
        begin
            filt_mem[col_reg] <= v_reg;
        end
        if (cmd.read)
        begin
            center_reg <= raw_mem[col_reg];
            right_reg  <= raw_mem[right_addr];
            up_reg     <= filt_mem[col_reg];
        end
    end

    // neighbors: up (filtered), down (raw), left (filtered), right (raw)
    always_comb
    begin
        nb[0] = up_reg;
        nb[1] = px_reg;
        nb[2] = left_reg;
        nb[3] = right_reg;
        nb_ok[0] = cmd.flush || (row_reg >= RW'(2));
        nb_ok[1] = !cmd.flush;
        nb_ok[2] = (col_reg != '0);
        nb_ok[3] = (CW'(col_reg) + CW'(1)) < ecols;
        any_close = 1'b0;
        sum       = '0;
        count     = '0;
        for (int k = 0; k < 4; k++)
        begin
            diff[k] = (center_reg > nb[k]) ? center_reg - nb[k] : nb[k] - center_reg;
            if (nb_ok[k])
            begin
                if (TW'(diff[k]) <= TW'(threshold))
                begin
                    any_close = 1'b1;
                end
                sum   = sum + SUM_BITS'(nb[k]);
                count = count + 3'd1;
            end
        end
    end

    // truncated average, divide by three through a reciprocal
    assign prod = PROD_BITS'(sum_reg) * PROD_BITS'(DIV3_MULT);

    always_comb
    begin
        case (count_reg)
            3'd2:    quot = sum_reg >> 1;
            3'd3:    quot = SUM_BITS'(prod >> DIV3_SHIFT);
            3'd4:    quot = sum_reg >> 2;
            default: quot = sum_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            keep_reg  <= any_close;
            sum_reg   <= sum;
            count_reg <= count;
        end
        if (cmd.div)
        begin
            v_reg <= keep_reg ? center_reg : quot[PW-1:0];
        end
    end

    assign v_wide   = IN_W'(v_reg);
    assign row_emit = cmd.flush ? row_reg : row_reg - RW'(1);
    assign row_wide = ROWX'(row_emit);
    assign col_wide = COLX'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_pix_reg  <= v_wide[idf_pkg::PIXEL_FIELD_W-1:0];
            out_row_reg  <= row_wide[idf_pkg::ROW_FIELD_W-1:0];
            out_col_reg  <= col_wide[idf_pkg::COL_FIELD_W-1:0];
            out_last_reg <= cmd.flush ? flush_last : !frame_end_reg;
            out_done_reg <= cmd.flush && flush_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{PAD_W{1'b0}}, out_col_reg, out_row_reg, out_pix_reg};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_done_reg;

endmodule

### test/idf_stream_check.sv
// stream checker for the image deglitch filter: raster prediction and output compare
`timescale 1ns / 1ps

module idf_stream_check
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [idf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [idf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              m_tlast,
    input  logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [idf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [idf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                pending,
    output int                                mismatches
);

    localparam int PIX_W      = idf_pkg::PIXEL_FIELD_W;
    localparam int ROW_W      = idf_pkg::ROW_FIELD_W;
    localparam int COL_W      = idf_pkg::COL_FIELD_W;
    localparam int LINE_LEN   = 32;
    localparam int ROW_LIMIT  = 32;
    localparam int ROW_LSB    = PIX_W;
    localparam int COL_LSB    = ROW_LSB + ROW_W;
    localparam int PAD_LSB    = COL_LSB + COL_W;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t             value;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last;
        logic               done;
    } filtered_px_t;

    filtered_px_t                          due_pixels[$];
    logic [idf_pkg::SIZE_REG_W-1:0]        rows_reg;
    logic [idf_pkg::SIZE_REG_W-1:0]        cols_reg;
    logic [idf_pkg::THRESH_REG_W-1:0]      thresh_reg;
    pixel_t                                raw_row   [LINE_LEN];
    pixel_t                                clean_row [LINE_LEN];
    pixel_t                                left_clean;
    int                                    row_pos;
    int                                    col_pos;
    int                                    err_total = 0;

    function automatic int fit_size(input int v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // keep the pixel unless it is far from every neighbor, else neighbor mean
    function automatic pixel_t settle_pixel(input pixel_t center,
                                            input logic [3:0][PIX_W-1:0] nb,
                                            input int n);
        int sum;
        int diff;
        sum = 0;
        for (int k = 0; k < n; k++)
        begin
            diff = int'(center) - int'(nb[k]);
            if (diff < 0)
                diff = -diff;
            if (diff <= int'(thresh_reg))
                return center;
            sum += int'(nb[k]);
        end
        return pixel_t'(sum / n);
    endfunction

    task automatic push_pixel(input pixel_t v, input int r, input int c,
                              input logic last, input logic done);
        filtered_px_t item;
        item.value = v;
        item.row   = r[ROW_W-1:0];
        item.col   = c[COL_W-1:0];
        item.last  = last;
        item.done  = done;
        due_pixels.push_back(item);
    endtask

    task automatic advance_raster(input pixel_t px);
        int                        erows;
        int                        ecols;
        int                        n;
        logic                      closes;
        logic [3:0][PIX_W-1:0]     nb;
        pixel_t                    v;
        erows = fit_size(int'(rows_reg), ROW_LIMIT);
        ecols = fit_size(int'(cols_reg), LINE_LEN);
        if (col_pos >= ecols)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= erows)
            row_pos = 0;
        closes = (row_pos == erows - 1) && (col_pos == ecols - 1);
        nb = '0;
        if (row_pos == 0)
            raw_row[col_pos] = px;
        else
        begin
            // row above the emitted one exists only from the second emitted row on
            n = 0;
            if (row_pos > 1)
            begin
                nb[n] = clean_row[col_pos];
                n++;
            end
            nb[n] = px;
            n++;
            if (col_pos > 0)
            begin
                nb[n] = left_clean;
                n++;
            end
            if (col_pos + 1 < ecols)
            begin
                nb[n] = raw_row[col_pos + 1];
                n++;
            end
            v = settle_pixel(raw_row[col_pos], nb, n);
            clean_row[col_pos] = v;
            left_clean = v;
            raw_row[col_pos] = px;
            push_pixel(v, row_pos - 1, col_pos, !closes, 1'b0);
        end
        if (closes)
        begin
            // flush of the final row, it has no row below
            for (int j = 0; j < ecols; j++)
            begin
                n = 0;
                nb[n] = clean_row[j];
                n++;
                if (j > 0)
                begin
                    nb[n] = left_clean;
                    n++;
                end
                if (j + 1 < ecols)
                begin
                    nb[n] = raw_row[j + 1];
                    n++;
                end
                v = settle_pixel(raw_row[j], nb, n);
                clean_row[j] = v;
                left_clean = v;
                push_pixel(v, erows - 1, j, j + 1 == ecols, j + 1 == ecols);
            end
            row_pos = 0;
            col_pos = 0;
        end
        else
            col_pos++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        err_total++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic compare_output();
        filtered_px_t want;
        if (due_pixels.size() == 0)
            report_mismatch("output item with nothing outstanding", int'(m_tdata), 0);
        else
        begin
            want = due_pixels.pop_front();
            if (m_tdata[PIX_W-1:0] != want.value)
                report_mismatch("out_pixel", int'(m_tdata[PIX_W-1:0]),
                                int'(want.value));
            if (m_tdata[ROW_LSB +: ROW_W] != want.row)
                report_mismatch("out_row", int'(m_tdata[ROW_LSB +: ROW_W]),
                                int'(want.row));
            if (m_tdata[COL_LSB +: COL_W] != want.col)
                report_mismatch("out_col", int'(m_tdata[COL_LSB +: COL_W]),
                                int'(want.col));
            if (m_tdata[idf_pkg::M_TDATA_W-1:PAD_LSB] != '0)
                report_mismatch("tdata padding",
                                int'(m_tdata[idf_pkg::M_TDATA_W-1:PAD_LSB]), 0);
            if (m_tlast != want.last)
                report_mismatch("last_in_run", int'(m_tlast), int'(want.last));
            if (m_tuser[0] != want.done)
                report_mismatch("frame_done", int'(m_tuser[0]), int'(want.done));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_pixels.delete();
            rows_reg   = idf_pkg::ROWS_RESET;
            cols_reg   = idf_pkg::COLS_RESET;
            thresh_reg = idf_pkg::THRESH_RESET;
            left_clean = '0;
            row_pos    = 0;
            col_pos    = 0;
            for (int k = 0; k < LINE_LEN; k++)
            begin
                raw_row[k]   = '0;
                clean_row[k] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    idf_pkg::CFG_ROWS:
                        rows_reg   = cfg_data[idf_pkg::SIZE_REG_W-1:0];
                    idf_pkg::CFG_COLS:
                        cols_reg   = cfg_data[idf_pkg::SIZE_REG_W-1:0];
                    idf_pkg::CFG_THRESHOLD:
                        thresh_reg = cfg_data[idf_pkg::THRESH_REG_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_raster(s_tdata[PIX_W-1:0]);
            if (m_tvalid && m_tready)
                compare_output();
        end
        pending    <= due_pixels.size();
        mismatches <= err_total;
    end

endmodule

### test/tb_top.sv
// testbench top for the image deglitch filter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_WAIT      = 17;
    localparam int SETTLE_CYCLES = 8;    // covers a row 0 pixel still in flight
    localparam int TAIL_CYCLES   = 20;
    localparam int HANG_LIMIT    = 2000; // cycles with no item moving on any channel
    localparam int PIXEL_TARGET  = 320;

    // index with no register behind it, the write must change nothing
    localparam logic [idf_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {IMG_NOISE, IMG_SPECKLE, IMG_FLAT} image_style_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic [idf_pkg::S_TDATA_W-1:0]       s_tdata   = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [idf_pkg::M_TDATA_W-1:0]       m_tdata;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic                                m_tlast;
    logic [0:0]                          m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [idf_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [idf_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    int pending;
    int mismatches;
    int pixels_sent   = 0;
    int frames_closed = 0;
    int hang_cycles;
    int cur_rows      = idf_pkg::ROWS_RESET;
    int cur_cols      = idf_pkg::COLS_RESET;
    bit gap_on        = 1'b0;   // sender draws a gap before each item
    bit stall_on      = 1'b0;   // receiver draws a stall before each item

    image_deglitch_filter DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),    // [7:0] in_pixel
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),    // [7:0] out_pixel, [12:8] out_row, [17:13] out_col
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),    // last_in_run
        .m_tuser   (m_tuser),    // [0] frame_done
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    idf_stream_check stream_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        forever
            #HALF_PERIOD clk = ~clk;
    end

    // end-of-frame results seen, lets the sender find the close of a frame
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready && m_tuser[0])
            frames_closed <= frames_closed + 1;
    end

    // output side: random stall before each item, ready held until it moves
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = stall_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // watchdog: ends the run when no item moves for too long
    initial
    begin
        hang_cycles = 0;
        while (hang_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                hang_cycles = 0;
            else
                hang_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic int fit_size(input int v);
        if (v < 2)
            return 2;
        if (v > 32)
            return 32;
        return v;
    endfunction

    function automatic logic [7:0] make_pixel(input image_style_t style, input int base);
        int v;
        case (style)
            IMG_FLAT:
                v = base;
            IMG_SPECKLE:
                // mostly a near-flat background, now and then an isolated spike
                if ($urandom_range(0, 6) == 0)
                    v = int'($urandom_range(0, 255));
                else
                    v = base + int'($urandom_range(0, 6)) - 3;
            default:
                v = int'($urandom_range(0, 255));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // valid stays high after the item moves, the caller lowers it before idling
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        gap = gap_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
    endtask

    // stop sending and wait for every outstanding result, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [idf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [idf_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int rows, input int cols, input int thr);
        write_reg(idf_pkg::CFG_ROWS, 8'(rows));
        write_reg(idf_pkg::CFG_COLS, 8'(cols));
        write_reg(idf_pkg::CFG_THRESHOLD, 8'(thr));
        cur_rows = rows;
        cur_cols = cols;
    endtask

    // one whole frame from a frame boundary, with an occasional full pause
    task automatic send_frame(input image_style_t style);
        int total;
        int base;
        total = fit_size(cur_rows) * fit_size(cur_cols);
        base  = $urandom_range(0, 255);
        for (int k = 0; k < total; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                drain_results();
            send_pixel(make_pixel(style, base));
        end
        drain_results();
    endtask

    // one item at a time until the frame closes, used after mid-frame size changes
    task automatic finish_frame(input int base);
        int seen;
        seen = frames_closed;
        while (frames_closed == seen)
        begin
            send_pixel(make_pixel(IMG_SPECKLE, base));
            drain_results();
        end
    endtask

    initial
    begin
        int rows;
        int cols;
        int thr;
        int round;
        image_style_t style;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sizes below the minimum clamp to 2x2; threshold 0, corner pixel far
        // from both neighbors gets their mean
        set_geometry(0, 1, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd255);
        drain_results();

        // checkerboard, every pixel disagrees with all its edge neighbors
        gap_on   = 1'b1;
        stall_on = 1'b1;
        write_reg(CFG_SPARE, 8'hFF);
        set_geometry(2, 3, 254);
        for (int k = 0; k < 6; k++)
            send_pixel(k % 2 == 0 ? 8'd255 : 8'd0);
        drain_results();

        // 3x3 with a spike in the center (four neighbors) and in the last corner
        set_geometry(3, 3, 10);
        send_pixel(8'd50);
        send_pixel(8'd52);
        send_pixel(8'd48);
        send_pixel(8'd49);
        send_pixel(8'd200);
        send_pixel(8'd51);
        send_pixel(8'd50);
        send_pixel(8'd47);
        send_pixel(8'd0);
        drain_results();

        // threshold at the top, nothing may change
        gap_on   = 1'b0;
        stall_on = 1'b0;
        set_geometry(2, 2, 255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        drain_results();

        // sizes shrunk mid-frame: fewer columns wraps the row early, fewer rows
        // than the current one restarts at row 0 without a flush
        gap_on   = 1'b1;
        stall_on = 1'b1;
        set_geometry(6, 10, $urandom_range(0, 12));
        repeat (25) send_pixel(make_pixel(IMG_SPECKLE, 90));
        drain_results();
        write_reg(idf_pkg::CFG_COLS, 8'd4);
        cur_cols = 4;
        repeat (3) send_pixel(make_pixel(IMG_SPECKLE, 90));
        drain_results();
        write_reg(idf_pkg::CFG_ROWS, 8'd2);
        cur_rows = 2;
        finish_frame(90);

        // random frames, mostly small, a few at the size extremes
        round = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            rows = $urandom_range(0, 8);
            cols = $urandom_range(0, 10);
            if (round == 2)
            begin
                rows = 63;
                cols = 2;
            end
            else if (round == 5)
            begin
                rows = 2;
                cols = 32;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                rows = $urandom_range(0, 3);
                cols = $urandom_range(33, 63);
            end
            case ($urandom_range(0, 3))
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = $urandom_range(0, 255);
                default: thr = $urandom_range(0, 16);
            endcase
            style    = image_style_t'($urandom_range(0, 2));
            gap_on   = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            if (round > 5 && $urandom_range(0, 2) == 0)
                write_reg(idf_pkg::CFG_THRESHOLD, 8'(thr));   // keep the frame size
            else
                set_geometry(rows, cols, thr);
            send_frame(style);
            round++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### image_deglitch_filter.f
hw/rtl/idf_pkg.sv
hw/rtl/idf_ctrl.sv
hw/rtl/idf_datapath.sv
hw/rtl/image_deglitch_filter.sv
test/idf_stream_check.sv
test/tb_top.sv
